// File: rtl/vrst_pkg.sv
// Package: shared types, constants and tables for the vertex transform block.
package vrst_pkg;

	localparam int NumRegs      = 7;
	localparam int AtanLen      = 24;
	localparam int FullTurn     = 23040;
	localparam int HalfTurn     = 11520;
	localparam int QuarterTurn  = 5760;
	localparam int DegToRadQ24  = 292818;
	localparam int CordicStartQ30 = 652032874;
	localparam logic [31:0] OneQ16 = 32'sd65536;

	typedef enum logic [2:0] {
		REG_SCALE_X = 3'd0,
		REG_SCALE_Y = 3'd1,
		REG_SCALE_Z = 3'd2,
		REG_ANGLES  = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		BLD_IDLE,
		BLD_CORDIC,
		BLD_RZRY,
		BLD_RXMUL,
		BLD_SCALE,
		BLD_DONE
	} bld_state_t;

	// Status between builder and top level.
	typedef struct packed {
		logic busy;
		logic done;
	} bld_status_t;

	function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 32'sd843314857;
			5'd1:  atan_q30 = 32'sd497837829;
			5'd2:  atan_q30 = 32'sd263043837;
			5'd3:  atan_q30 = 32'sd133525159;
			5'd4:  atan_q30 = 32'sd67021687;
			5'd5:  atan_q30 = 32'sd33543516;
			5'd6:  atan_q30 = 32'sd16775851;
			5'd7:  atan_q30 = 32'sd8388437;
			5'd8:  atan_q30 = 32'sd4194283;
			5'd9:  atan_q30 = 32'sd2097149;
			5'd10: atan_q30 = 32'sd1048576;
			5'd11: atan_q30 = 32'sd524288;
			5'd12: atan_q30 = 32'sd262144;
			5'd13: atan_q30 = 32'sd131072;
			5'd14: atan_q30 = 32'sd65536;
			5'd15: atan_q30 = 32'sd32768;
			5'd16: atan_q30 = 32'sd16384;
			5'd17: atan_q30 = 32'sd8192;
			5'd18: atan_q30 = 32'sd4096;
			5'd19: atan_q30 = 32'sd2048;
			5'd20: atan_q30 = 32'sd1024;
			5'd21: atan_q30 = 32'sd512;
			5'd22: atan_q30 = 32'sd256;
			5'd23: atan_q30 = 32'sd128;
			default: atan_q30 = 32'sd0;
		endcase
	endfunction

	// Saturate a 66-bit value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh0_7FFF_FFFF)
			sat32 = 32'sh7FFF_FFFF;
		else if (v < -66'sh0_8000_0000)
			sat32 = 32'sh8000_0000;
		else
			sat32 = v[31:0];
	endfunction

endpackage

// File: rtl/vrst_cordic.sv
// Iterative CORDIC sine/cosine for one Q10.6 degree angle, one step per cycle.
module vrst_cordic
	import vrst_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        angle,
	output logic               done,
	output logic signed [31:0] cos_q16,
	output logic signed [31:0] sin_q16
);

	localparam int NSteps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

	logic               run_q;
	logic [4:0]         step_q;
	logic               neg_q;
	logic signed [33:0] x_q, y_q;
	logic signed [39:0] z_q;
	logic               done_q;

	// Angle reduction, combinational on the start cycle.
	logic signed [15:0] a_raw;
	logic signed [15:0] a_mod;
	logic signed [15:0] a_wrap;
	logic signed [15:0] a_red;
	logic               a_neg;
	logic signed [39:0] z_init;

	always_comb begin
		a_raw = angle;
		// |a_raw| <= 32768 < 2*FullTurn: remainder by a single conditional add or subtract
		a_mod = a_raw;
		if (a_mod >= 16'(FullTurn))
			a_mod = a_mod - 16'(FullTurn);
		else if (a_mod <= -16'(FullTurn))
			a_mod = a_mod + 16'(FullTurn);
		a_wrap = a_mod;
		if (a_wrap >= 16'(HalfTurn))
			a_wrap = a_wrap - 16'(FullTurn);
		if (a_wrap < -16'(HalfTurn))
			a_wrap = a_wrap + 16'(FullTurn);
		a_red = a_wrap;
		a_neg = 1'b0;
		if (a_red > 16'(QuarterTurn)) begin
			a_red = a_red - 16'(HalfTurn);
			a_neg = 1'b1;
		end else if (a_red < -16'(QuarterTurn)) begin
			a_red = a_red + 16'(HalfTurn);
			a_neg = 1'b1;
		end
		z_init = 40'(a_red) * 40'sd292818;
	end

	logic signed [33:0] x_sh, y_sh;
	logic signed [39:0] at;
	always_comb begin
		x_sh = x_q >>> step_q;
		y_sh = y_q >>> step_q;
		at   = 40'(atan_q30(step_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == 5'(NSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= 34'sd652032874;
			y_q   <= '0;
			z_q   <= z_init;
			neg_q <= a_neg;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + at;
			end
		end
	end

	logic signed [33:0] c_r, s_r;
	always_comb begin
		c_r = (x_q + 34'sd8192) >>> 14;
		s_r = (y_q + 34'sd8192) >>> 14;
		cos_q16 = neg_q ? -c_r[31:0] : c_r[31:0];
		sin_q16 = neg_q ? -s_r[31:0] : s_r[31:0];
	end

	assign done = done_q;

endmodule

// File: rtl/vrst_builder.sv
// Matrix builder: three CORDIC passes, then two sequenced 3x3 products and scale.
module vrst_builder
	import vrst_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [47:0]        angles,
	input  logic signed [31:0] scale [3],
	output bld_status_t        status,
	output logic [3:0]         wr_idx,
	output logic               wr_en,
	output logic signed [31:0] wr_data
);

	bld_state_t state_q, state_d;
	logic [1:0] ang_q, ang_d;
	logic [3:0] ent_q, ent_d;
	logic       c_start;
	logic       c_done;
	logic [15:0] c_angle;
	logic signed [31:0] c_cos, c_sin;

	logic signed [31:0] cs_q [3];
	logic signed [31:0] sn_q [3];
	logic signed [31:0] t_q  [9];
	logic signed [31:0] r_q;

	vrst_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .angle(c_angle),
		.done(c_done), .cos_q16(c_cos), .sin_q16(c_sin)
	);

	// The CORDIC samples its angle on the start cycle, so pick the one being launched.
	assign c_angle = angles[16*ang_d +: 16];

	// Rotation matrices built from stored sin/cos; index 0 z, 1 y, 2 x.
	function automatic logic signed [31:0] rz(input int i, input int j,
		input logic signed [31:0] c, input logic signed [31:0] s);
		logic signed [31:0] m [9];
		m = '{c, s, 32'sd0, -s, c, 32'sd0, 32'sd0, 32'sd0, OneQ16};
		rz = m[i*3+j];
	endfunction
	function automatic logic signed [31:0] ry(input int i, input int j,
		input logic signed [31:0] c, input logic signed [31:0] s);
		logic signed [31:0] m [9];
		m = '{c, 32'sd0, s, 32'sd0, OneQ16, 32'sd0, -s, 32'sd0, c};
		ry = m[i*3+j];
	endfunction
	function automatic logic signed [31:0] rx(input int i, input int j,
		input logic signed [31:0] c, input logic signed [31:0] s);
		logic signed [31:0] m [9];
		m = '{OneQ16, 32'sd0, 32'sd0, 32'sd0, c, s, 32'sd0, -s, c};
		rx = m[i*3+j];
	endfunction

	logic [1:0] ei, ej;
	logic [3:0] tidx;
	always_comb begin
		ei = (ent_q >= 4'd6) ? 2'd2 : ((ent_q >= 4'd3) ? 2'd1 : 2'd0);
		ej = 2'(ent_q - 4'(ei) * 4'd3);
		tidx = ent_q;
	end

	// One entry of a 3x3 product per cycle: three 32x32 products summed.
	logic signed [65:0] acc;
	logic signed [65:0] p0, p1, p2;
	logic signed [31:0] rot_e;
	always_comb begin
		p0 = '0; p1 = '0; p2 = '0;
		if (state_q == BLD_RZRY) begin
			p0 = 66'(rz(int'(ei), 0, cs_q[0], sn_q[0])) * 66'(ry(0, int'(ej), cs_q[1], sn_q[1]));
			p1 = 66'(rz(int'(ei), 1, cs_q[0], sn_q[0])) * 66'(ry(1, int'(ej), cs_q[1], sn_q[1]));
			p2 = 66'(rz(int'(ei), 2, cs_q[0], sn_q[0])) * 66'(ry(2, int'(ej), cs_q[1], sn_q[1]));
		end else begin
			p0 = 66'(t_q[ei*3+0]) * 66'(rx(0, int'(ej), cs_q[2], sn_q[2]));
			p1 = 66'(t_q[ei*3+1]) * 66'(rx(1, int'(ej), cs_q[2], sn_q[2]));
			p2 = 66'(t_q[ei*3+2]) * 66'(rx(2, int'(ej), cs_q[2], sn_q[2]));
		end
		acc = p0 + p1 + p2;
		rot_e = 32'((acc + 66'sd32768) >>> 16);
	end

	// Scale stage: register rotation entry, then multiply by scale of its column.
	logic [3:0] sc_ent_q;
	logic       sc_vld_q;
	logic [1:0] sc_i, sc_j;
	logic signed [65:0] sc_prod;
	always_comb begin
		sc_i = (sc_ent_q >= 4'd6) ? 2'd2 : ((sc_ent_q >= 4'd3) ? 2'd1 : 2'd0);
		sc_j = 2'(sc_ent_q - 4'(sc_i) * 4'd3);
		sc_prod = (66'(r_q) * 66'(scale[sc_j]) + 66'sd32768) >>> 16;
	end

	always_comb begin
		state_d = state_q;
		ang_d   = ang_q;
		ent_d   = ent_q;
		c_start = 1'b0;
		unique case (state_q)
			BLD_IDLE: begin
				if (start) begin
					state_d = BLD_CORDIC;
					ang_d   = 2'd0;
					c_start = 1'b1;
				end
			end
			BLD_CORDIC: begin
				if (c_done) begin
					if (ang_q == 2'd2) begin
						state_d = BLD_RZRY;
						ent_d   = '0;
					end else begin
						ang_d   = ang_q + 2'd1;
						c_start = 1'b1;
					end
				end
			end
			BLD_RZRY: begin
				ent_d = ent_q + 4'd1;
				if (ent_q == 4'd8) begin
					state_d = BLD_RXMUL;
					ent_d   = '0;
				end
			end
			BLD_RXMUL: begin
				ent_d = ent_q + 4'd1;
				if (ent_q == 4'd8)
					state_d = BLD_SCALE;
			end
			BLD_SCALE: state_d = BLD_DONE;
			BLD_DONE:  state_d = BLD_IDLE;
			default:   state_d = BLD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BLD_IDLE;
			ang_q    <= '0;
			ent_q    <= '0;
			sc_vld_q <= 1'b0;
			sc_ent_q <= '0;
		end else begin
			state_q  <= state_d;
			ang_q    <= ang_d;
			ent_q    <= ent_d;
			sc_vld_q <= (state_q == BLD_RXMUL);
			sc_ent_q <= ent_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BLD_CORDIC && c_done) begin
			cs_q[ang_q] <= c_cos;
			sn_q[ang_q] <= c_sin;
		end
		if (state_q == BLD_RZRY)
			t_q[tidx] <= rot_e;
		if (state_q == BLD_RXMUL)
			r_q <= rot_e;
	end

	assign wr_en   = sc_vld_q;
	assign wr_idx  = 4'({2'b00, sc_i} * 4'd4 + {2'b00, sc_j});
	assign wr_data = sat32(sc_prod);
	assign status.busy = (state_q != BLD_IDLE);
	assign status.done = (state_q == BLD_DONE);

endmodule

// File: rtl/vrst_datapath.sv
// Vertex pipeline: products, row sums, rounding and saturation over four stages.
module vrst_datapath
	import vrst_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	output logic               in_rdy,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [31:0] vz,
	input  logic signed [31:0] mat [12],
	output logic               out_vld,
	input  logic               out_rdy,
	output logic signed [31:0] ox,
	output logic signed [31:0] oy,
	output logic signed [31:0] oz
);

	logic       v_s1, v_s2, v_s3, v_s4;
	logic       adv1, adv2, adv3, adv4;
	logic signed [63:0] p_s1 [9];
	logic signed [31:0] t_s1 [3];
	logic signed [49:0] hi_s2 [3];
	logic [17:0]        lo_s2 [3];
	logic signed [31:0] t_s2 [3];
	logic signed [51:0] sum_s3 [3];
	logic signed [31:0] o_s4 [3];

	assign adv4 = !v_s4 || out_rdy;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_rdy = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_vld;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	localparam logic signed [51:0] SatHi = 52'sd2 ** (COORD_WIDTH - 1) - 52'sd1;
	localparam logic signed [51:0] SatLo = -(52'sd2 ** (COORD_WIDTH - 1));

	logic signed [31:0] vin [3];
	assign vin = '{vx, vy, vz};

	always_ff @(posedge clk) begin
		if (adv1 && in_vld) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					p_s1[i*3+j] <= 64'(mat[i*4+j]) * 64'(vin[j]);
				t_s1[i] <= mat[i*4+3];
			end
		end
		if (adv2 && v_s1) begin
			// truncated high part plus low fraction keeps the sum exact
			for (int i = 0; i < 3; i++) begin
				hi_s2[i] <= 50'(p_s1[i*3] >>> 16) + 50'(p_s1[i*3+1] >>> 16)
					+ 50'(p_s1[i*3+2] >>> 16);
				lo_s2[i] <= 18'({2'b00, p_s1[i*3][15:0]}) + 18'({2'b00, p_s1[i*3+1][15:0]})
					+ 18'({2'b00, p_s1[i*3+2][15:0]});
				t_s2[i] <= t_s1[i];
			end
		end
		if (adv3 && v_s2) begin
			for (int i = 0; i < 3; i++)
				sum_s3[i] <= 52'(hi_s2[i]) + 52'((lo_s2[i] + 18'd32768) >> 16)
					+ 52'(t_s2[i]);
		end
		if (adv4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				if (sum_s3[i] > SatHi)
					o_s4[i] <= 32'(SatHi);
				else if (sum_s3[i] < SatLo)
					o_s4[i] <= 32'(SatLo);
				else
					o_s4[i] <= sum_s3[i][31:0];
			end
		end
	end

	assign out_vld = v_s4;
	assign ox = o_s4[0];
	assign oy = o_s4[1];
	assign oz = o_s4[2];

endmodule

// File: rtl/vertex_rotate_scale_translate.sv
// Top level: vertex transform with APB registers, matrix builder and vertex pipeline.
//
//  channel  | handshake          | payload
//  in       | in_valid/in_ready  | in_x, in_y, in_z
//  out      | out_valid/out_ready| out_x, out_y, out_z
//  cfg      | APB psel/penable   | paddr, pwdata, prdata
//
// One vertex per cycle through a four-stage pipeline, unless out_ready stalls it
// or a build is pending. After reset or any register write the first vertex
// waits for a matrix build: a start pulse, three CORDIC runs, then the 3x3
// products, scaling and hand-off.
// Reset clears valid bits and control; stalls hold full stages, not bubbles.
module vertex_rotate_scale_translate
	import vrst_pkg::*;
#(
	parameter int COORD_WIDTH  = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	logic signed [31:0] scale_q [3];
	logic [47:0]        angles_q;
	logic signed [31:0] shift_q [3];
	logic signed [31:0] mat_q [12];
	logic               ready_q;
	logic               wr;
	logic [2:0]         ridx;
	logic               bld_start;
	bld_status_t        bst;
	logic [3:0]         b_idx;
	logic               b_en;
	logic signed [31:0] b_data;
	logic               dp_in_vld, dp_in_rdy;
	logic signed [31:0] mat_v [12];

	assign pready = 1'b1;
	assign wr   = psel && penable && pwrite;
	assign ridx = paddr[5:3];

	always_comb begin
		prdata = '0;
		unique case (ridx)
			REG_SCALE_X: prdata = 64'(unsigned'(scale_q[0]));
			REG_SCALE_Y: prdata = 64'(unsigned'(scale_q[1]));
			REG_SCALE_Z: prdata = 64'(unsigned'(scale_q[2]));
			REG_ANGLES:  prdata = 64'(angles_q);
			REG_SHIFT_X: prdata = 64'(unsigned'(shift_q[0]));
			REG_SHIFT_Y: prdata = 64'(unsigned'(shift_q[1]));
			REG_SHIFT_Z: prdata = 64'(unsigned'(shift_q[2]));
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= '{OneQ16, OneQ16, OneQ16};
			angles_q <= '0;
			shift_q  <= '{32'sd0, 32'sd0, 32'sd0};
			ready_q  <= 1'b0;
			for (int i = 0; i < 12; i++)
				mat_q[i] <= (i % 5 == 0) ? OneQ16 : 32'sd0;
		end else begin
			if (wr && 32'(ridx) < NumRegs) begin
				ready_q <= 1'b0;
				unique case (ridx)
					REG_SCALE_X: scale_q[0] <= pwdata[31:0];
					REG_SCALE_Y: scale_q[1] <= pwdata[31:0];
					REG_SCALE_Z: scale_q[2] <= pwdata[31:0];
					REG_ANGLES:  angles_q   <= pwdata[47:0];
					REG_SHIFT_X: shift_q[0] <= pwdata[31:0];
					REG_SHIFT_Y: shift_q[1] <= pwdata[31:0];
					REG_SHIFT_Z: shift_q[2] <= pwdata[31:0];
					default: ;
				endcase
			end else if (bst.done) begin
				ready_q <= 1'b1;
			end
			if (b_en)
				mat_q[b_idx] <= b_data;
		end
	end

	// Start a build when a vertex waits and the matrix is stale.
	assign bld_start = in_valid && !ready_q && !bst.busy;

	vrst_builder #(.CORDIC_STEPS(CORDIC_STEPS)) u_builder (
		.clk(clk), .arst_n(arst_n), .start(bld_start), .angles(angles_q),
		.scale(scale_q), .status(bst), .wr_idx(b_idx), .wr_en(b_en), .wr_data(b_data)
	);

	always_comb begin
		mat_v = mat_q;
		mat_v[3]  = shift_q[0];
		mat_v[7]  = shift_q[1];
		mat_v[11] = shift_q[2];
	end

	assign dp_in_vld = in_valid && ready_q;
	assign in_ready  = dp_in_rdy && ready_q;

	vrst_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_vld(dp_in_vld), .in_rdy(dp_in_rdy),
		.vx(in_x), .vy(in_y), .vz(in_z), .mat(mat_v),
		.out_vld(out_valid), .out_rdy(out_ready), .ox(out_x), .oy(out_y), .oz(out_z)
	);

	a_no_accept_stale: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ready_q) else $error("vertex taken on stale matrix");
	a_build_clears: assert property (@(posedge clk) disable iff (!arst_n)
		wr && ridx == REG_ANGLES |=> !ready_q) else $error("angle write kept matrix ready");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule
